[design/bbpps_pkg.sv]
// Shared types and constants for the BBP pi partial-sum block.
// Used by bbpps_ctrl, bbpps_dp and bbp_pi_partial_sum_core; depends on nothing.
`default_nettype none
package bbpps_pkg;

	localparam int N_W   = 32;	// term count field
	localparam int S_W   = 7;	// stride field
	localparam int O_W   = 6;	// offset field
	localparam int SUM_W = 62;	// partial sum field
	localparam int K_W   = 8;	// term index; holds 15 + 127 after a step
	localparam int DEN_W = 7;	// divisor 8k+6 with k below 16
	localparam int SEL_W = 2;

	// Which of the four divisions of a term is running.
	localparam logic [SEL_W-1:0] SEL_A = 2'd0;	// 4*2^F / (8k+1)
	localparam logic [SEL_W-1:0] SEL_B = 2'd1;	// 2*2^F / (8k+4)
	localparam logic [SEL_W-1:0] SEL_C = 2'd2;	// 2^F / (8k+5)
	localparam logic [SEL_W-1:0] SEL_D = 2'd3;	// 2^F / (8k+6)

	typedef struct packed {
		logic             load;
		logic             div_init;
		logic             div_step;
		logic             term;
		logic             adv;
		logic             publish;
		logic [SEL_W-1:0] sel;
	} cmd_t;

	typedef struct packed {
		logic k_ok;
		logic div_last;
		logic stride_zero;
	} sts_t;

endpackage
`default_nettype wire

[design/bbp_pi_partial_sum_core.sv]
// BBP pi partial-sum block, top level: links bbpps_ctrl and bbpps_dp; uses bbpps_pkg.
//
// Usage: a request (term_count, stride, offset) transfers on the input
// channel when in_valid is high and in_stall is low. The block sums the
// Bailey-Borwein-Plouffe terms k = offset, offset+stride, ... below
// min(term_count, MAX_TERMS) in fixed point with FRAC_BITS fraction bits and
// returns one partial_sum on the output channel (out_valid / out_stall).
// A stride of zero sums only the term at the offset.
// Each term takes four bit-serial divisions of FRAC_BITS+3 steps, each
// after a setup state, then combine, add and check states; with a zero
// stride the check after the add is skipped. The next request can
// transfer once the sum is in the output register. One request is worked
// at a time; in_stall is high from acceptance until the result is handed
// to the output register.
// The output register frees the core: if the receiver stalls, the finished
// sum waits there and the next request may already be accepted; a later
// result waits in the core until the register is transferred.
// Reset (arst_n low) clears the controller and drops out_valid.
`default_nettype none
module bbp_pi_partial_sum_core
	import bbpps_pkg::*;
#(
	parameter int FRAC_BITS = 60,
	parameter int MAX_TERMS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [N_W-1:0]   term_count,
	input  wire logic [S_W-1:0]   stride,
	input  wire logic [O_W-1:0]   offset,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic      [SUM_W-1:0] partial_sum
);

	cmd_t cmd;
	sts_t sts;

	bbpps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bbpps_dp #(
		.FRAC_BITS (FRAC_BITS),
		.MAX_TERMS (MAX_TERMS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.term_count  (term_count),
		.stride      (stride),
		.offset      (offset),
		.partial_sum (partial_sum)
	);

endmodule
`default_nettype wire

[design/bbpps_dp.sv]
// Datapath of the BBP pi partial-sum block: request registers, bit-serial
// divider, term combine, saturating accumulator and result register. Uses bbpps_pkg.
`default_nettype none
module bbpps_dp
	import bbpps_pkg::*;
#(
	parameter int FRAC_BITS = 60,
	parameter int MAX_TERMS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cmd_t             cmd,
	output sts_t                  sts,
	input  wire logic [N_W-1:0]   term_count,
	input  wire logic [S_W-1:0]   stride,
	input  wire logic [O_W-1:0]   offset,
	output logic      [SUM_W-1:0] partial_sum
);

	localparam int QW    = FRAC_BITS + 3;	// holds 4*2^F
	localparam int CNT_W = $clog2(QW);

	logic [K_W-1:0]   k_q;
	logic [K_W-1:0]   limit_q;
	logic [S_W-1:0]   s_q;
	logic [SUM_W-1:0] acc_q;
	logic [SUM_W-1:0] partial_sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [QW-1:0]    quot_q;
	logic [QW-1:0]    a_q;
	logic [QW-1:0]    sub_q;
	logic [QW-1:0]    diff_q;

	logic [DEN_W-1:0] den;
	logic [CNT_W-1:0] num_pos;
	logic [DEN_W:0]   trial;
	logic             qbit;
	logic [DEN_W-1:0] rem_next;
	logic [QW-1:0]    quot_next;
	logic [QW-1:0]    term_val;
	logic [63:0]      sum_wide;

	// Divisor and position of the single set numerator bit for each division.
	always_comb begin
		case (cmd.sel)
			SEL_A: begin
				den     = {k_q[3:0], 3'd1};
				num_pos = CNT_W'(FRAC_BITS + 2);
			end
			SEL_B: begin
				den     = {k_q[3:0], 3'd4};
				num_pos = CNT_W'(FRAC_BITS + 1);
			end
			SEL_C: begin
				den     = {k_q[3:0], 3'd5};
				num_pos = CNT_W'(FRAC_BITS);
			end
			default: begin
				den     = {k_q[3:0], 3'd6};
				num_pos = CNT_W'(FRAC_BITS);
			end
		endcase
	end

	// One restoring step; numerator bits are shifted in MSB first.
	assign trial     = {rem_q, (cnt_q == num_pos)};
	assign qbit      = (trial >= {1'b0, den});
	assign rem_next  = qbit ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
	assign quot_next = {quot_q[QW-2:0], qbit};

	assign term_val = diff_q >> {k_q[3:0], 2'b00};
	assign sum_wide = {{(64-SUM_W){1'b0}}, acc_q} + {{(64-QW){1'b0}}, term_val};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			k_q     <= {{(K_W-O_W){1'b0}}, offset};
			s_q     <= stride;
			limit_q <= (term_count < N_W'(MAX_TERMS)) ? term_count[K_W-1:0]
			                                          : K_W'(MAX_TERMS);
			acc_q   <= '0;
		end
		if (cmd.div_init) begin
			cnt_q  <= CNT_W'(QW - 1);
			rem_q  <= '0;
			quot_q <= '0;
		end
		if (cmd.div_step) begin
			cnt_q  <= cnt_q - 1'b1;
			rem_q  <= rem_next;
			quot_q <= quot_next;
			if (cnt_q == '0) begin
				case (cmd.sel)
					SEL_A:   a_q   <= quot_next;
					SEL_B:   sub_q <= quot_next;
					default: sub_q <= sub_q + quot_next;
				endcase
			end
		end
		if (cmd.term) begin
			diff_q <= (sub_q > a_q) ? '0 : a_q - sub_q;
		end
		if (cmd.adv) begin
			acc_q <= (sum_wide > {{(64-SUM_W){1'b0}}, {SUM_W{1'b1}}}) ? {SUM_W{1'b1}}
			                                                       : sum_wide[SUM_W-1:0];
			k_q   <= k_q + {{(K_W-S_W){1'b0}}, s_q};
		end
		if (cmd.publish) begin
			partial_sum_q <= acc_q;
		end
	end

	assign sts.k_ok        = (k_q < limit_q);
	assign sts.div_last    = (cnt_q == '0);
	assign sts.stride_zero = (s_q == '0);
	assign partial_sum     = partial_sum_q;

`ifndef NO_ASSERTIONS
	// A division runs only on terms whose index is below sixteen.
	a_div_k_small: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (k_q < K_W'(16)))
		else $error("division started on a term index of sixteen or more");
	// The saturating add never leaves the accumulator below its previous value.
	a_acc_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.adv |=> (acc_q >= $past(acc_q)))
		else $error("accumulator decreased on a term add");
	// A division's last step never comes in the same cycle as the start of a new division.
	a_cnt_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && cnt_q == '0) |=> !$past(cmd.div_init))
		else $error("divider finished and restarted in one cycle");
`endif

endmodule
`default_nettype wire

[design/bbpps_ctrl.sv]
// Controller of the BBP pi partial-sum block: request sequencing and the
// output valid flag. Uses bbpps_pkg; drives the datapath in bbpps_dp.
`default_nettype none
module bbpps_ctrl
	import bbpps_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  wire logic out_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_DINIT = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_TERM  = 3'd4;
	localparam logic [2:0] S_ADV   = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0]       state_q;
	logic [2:0]       state_d;
	logic [SEL_W-1:0] sel_q;
	logic [SEL_W-1:0] sel_d;
	logic             out_valid_q;

	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		cmd     = '0;
		cmd.sel = sel_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				sel_d   = SEL_A;
				state_d = sts.k_ok ? S_DINIT : S_OUT;
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					if (sel_q == SEL_D) begin
						state_d = S_TERM;
					end else begin
						sel_d   = sel_q + 1'b1;
						state_d = S_DINIT;
					end
				end
			end
			S_TERM: begin
				cmd.term = 1'b1;
				state_d  = S_ADV;
			end
			S_ADV: begin
				cmd.adv = 1'b1;
				state_d = sts.stride_zero ? S_OUT : S_CHECK;
			end
			S_OUT: begin
				// The result register is free or its transfer happens now.
				if (!out_valid_q || !out_stall) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sel_q       <= SEL_A;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.div_init, cmd.div_step, cmd.term, cmd.adv, cmd.publish}))
		else $error("more than one datapath command in a cycle");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> !(out_valid_q && out_stall))
		else $error("result overwritten while waiting for transfer");
	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_CHECK))
		else $error("accepted request did not start the term loop");
	a_publish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> out_valid_q)
		else $error("published result not marked valid");
`endif

endmodule
`default_nettype wire
